// ----- rtl/core/rtpsrt_pkg.sv -----
package rtpsrt_pkg;

	localparam int MaxSources = 8;
	localparam int SlotBits = 3;
	localparam int CountBits = 4;
	localparam int QDepth = 3;
	localparam int TagBits = 8;
	localparam logic [15:0] MinLength = 16'd12;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_HDR = 3'd1;
	localparam logic [2:0] ST_BAD_PAD = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_OUT_SEQ = 3'd4;
	localparam logic [2:0] ST_DUP = 3'd5;

	localparam logic [1:0] REG_SOURCE_LIMIT = 2'd0;
	localparam logic [1:0] REG_DROPOUT = 2'd1;
	localparam logic [1:0] REG_MISORDER = 2'd2;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CHECK  = 7'b0000010,
		S_SEARCH = 7'b0000100,
		S_LOAD   = 7'b0001000,
		S_VALID  = 7'b0010000,
		S_INSERT = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

endpackage

// ----- rtl/core/rtpsrt_search.sv -----
module rtpsrt_search (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [31:0]                    key,
	input  logic [rtpsrt_pkg::MaxSources-1:0] used,
	input  logic [31:0]                    ssrc_rd,
	output logic [rtpsrt_pkg::SlotBits-1:0] idx,
	output logic                           busy,
	output logic                           hit
);

	logic [rtpsrt_pkg::SlotBits-1:0] idx_q;
	logic                            busy_q;
	logic                            hit_q;
	logic                            match;

	assign match = used[idx_q] && (ssrc_rd == key);
	assign idx = idx_q;
	assign busy = busy_q;
	assign hit = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			busy_q <= 1'b0;
			hit_q <= 1'b0;
		end else if (start) begin
			idx_q <= '0;
			busy_q <= 1'b1;
			hit_q <= 1'b0;
		end else if (busy_q) begin
			if (match) begin
				busy_q <= 1'b0;
				hit_q <= 1'b1;
			end else if (idx_q == rtpsrt_pkg::SlotBits'(rtpsrt_pkg::MaxSources - 1)) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	a_hit_used: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hit_q) |-> $past(used[idx_q])) else $error("hit on unused slot");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("search did not start");
	a_idle_hit: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> !busy_q) else $error("hit while busy");

endmodule

// ----- rtl/core/rtp_sequence_reorder_tracker.sv -----
// Tracks RTP sources and sorts their packets by sequence number.
// The input channel (in_valid/in_ready) takes one packet descriptor word.
// Each word yields exactly one result word on the output channel
// (out_valid/out_ready): a status, resync and flush details, and at most
// one released buffer handle with its sequence and gap flag.
// A word passes from acceptance to result through a header check, a
// slot search that reads one SSRC per cycle from the slot table, a load
// of the per-source state, the sequence check, and the sorted insert.
// A rejected header goes straight to the result and skips the search.
// No new word is taken while one is still being processed.
// The result is held in an output register; the next word is accepted once
// that register is taken, so a stalled receiver stalls the input.
// Configuration writes take effect at once and must be made while idle;
// the block does not enforce this. Reset clears the source table and all
// queues and restores the register defaults; no clearing pass is needed after reset.
module rtp_sequence_reorder_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] packet_length,
	input  logic [7:0]  header_byte0,
	input  logic [7:0]  final_byte,
	input  logic [15:0] sequence_req,
	input  logic [31:0] source_id,
	input  logic [7:0]  buffer_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        resynced,
	output logic [2:0]  slot,
	output logic [1:0]  flushed_count,
	output logic [7:0]  flushed_first,
	output logic [7:0]  flushed_second,
	output logic        release_valid,
	output logic [7:0]  release_tag,
	output logic [15:0] release_sequence,
	output logic        release_gap
);

	localparam int N = rtpsrt_pkg::MaxSources;
	localparam int SB = rtpsrt_pkg::SlotBits;
	localparam int TB = rtpsrt_pkg::TagBits;

	rtpsrt_pkg::state_t state_q;

	logic [3:0]  limit_q;
	logic [14:0] dropout_q;
	logic [14:0] misorder_q;

	logic [N-1:0] used_q;
	logic [31:0]  ssrc_mem [N];
	logic [15:0]  high_q [N];
	logic [15:0]  probe_q [N];
	logic [15:0]  rel_q [N];
	logic [1:0]   fill_q [N];
	logic [15:0]  qseq_q [N][rtpsrt_pkg::QDepth];
	logic [TB-1:0] qtag_q [N][rtpsrt_pkg::QDepth];
	logic [rtpsrt_pkg::CountBits-1:0] in_use_q;

	logic [15:0] len_q, seq_q;
	logic [7:0]  b0_q, last_q;
	logic [31:0] ssrc_q;
	logic [TB-1:0] tag_q;

	logic [SB-1:0] s_q;
	logic [15:0]  hi_q, pr_q, rl_q;
	logic [1:0]   fl_q;
	logic [15:0]  q0s_q, q1s_q;
	logic [TB-1:0] q0t_q, q1t_q;

	logic [2:0]  status_q;
	logic        resync_q;
	logic [2:0]  slot_q;
	logic [1:0]  fcnt_q;
	logic [7:0]  ff_q, fs_q;
	logic        rv_q, rg_q;
	logic [7:0]  rt_q;
	logic [15:0] rs_q;

	logic          srch_start;
	logic [SB-1:0] srch_idx;
	logic          srch_busy, srch_hit;

	logic [15:0] hi_eff, delta, d0, d1;
	logic        fwd, bad;
	logic [16:0] padneed;

	assign in_ready = (state_q == rtpsrt_pkg::S_IDLE) && !out_valid;
	assign srch_start = (state_q == rtpsrt_pkg::S_CHECK);

	rtpsrt_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (srch_start),
		.key     (ssrc_q),
		.used    (used_q),
		.ssrc_rd (ssrc_mem[srch_idx]),
		.idx     (srch_idx),
		.busy    (srch_busy),
		.hit     (srch_hit)
	);

	assign padneed = 17'(rtpsrt_pkg::MinLength) + 17'(last_q);

	assign hi_eff = (fl_q == 2'd0) ? seq_q - 16'(dropout_q) : hi_q;
	assign delta = seq_q - (hi_eff + 16'd1);
	assign fwd = !delta[15];
	assign bad = fwd ? (delta > 16'(dropout_q))
		: ((16'hffff - delta) > 16'(misorder_q));
	assign d0 = seq_q - q0s_q;
	assign d1 = seq_q - q1s_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtpsrt_pkg::S_IDLE;
			limit_q <= 4'd8;
			dropout_q <= 15'd3000;
			misorder_q <= 15'd100;
			used_q <= '0;
			in_use_q <= '0;
			s_q <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < N; i++) fill_q[i] <= 2'd0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					rtpsrt_pkg::REG_SOURCE_LIMIT: limit_q <= cfg_data[3:0];
					rtpsrt_pkg::REG_DROPOUT:      dropout_q <= cfg_data;
					rtpsrt_pkg::REG_MISORDER:     misorder_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				rtpsrt_pkg::S_IDLE: begin
					if (in_valid && in_ready) begin
						len_q <= packet_length;
						b0_q <= header_byte0;
						last_q <= final_byte;
						seq_q <= sequence_req;
						ssrc_q <= source_id;
						tag_q <= buffer_tag;
						state_q <= rtpsrt_pkg::S_CHECK;
					end
				end
				rtpsrt_pkg::S_CHECK: begin
					resync_q <= 1'b0;
					slot_q <= '0;
					fcnt_q <= '0;
					ff_q <= '0;
					fs_q <= '0;
					rv_q <= 1'b0;
					rt_q <= '0;
					rs_q <= '0;
					rg_q <= 1'b0;
					if (len_q < rtpsrt_pkg::MinLength || b0_q[7:6] != 2'd2) begin
						status_q <= rtpsrt_pkg::ST_BAD_HDR;
						state_q <= rtpsrt_pkg::S_DONE;
					end else if (b0_q[5] && (last_q == 8'd0 || {1'b0, len_q} < padneed)) begin
						status_q <= rtpsrt_pkg::ST_BAD_PAD;
						state_q <= rtpsrt_pkg::S_DONE;
					end else begin
						status_q <= rtpsrt_pkg::ST_OK;
						state_q <= rtpsrt_pkg::S_SEARCH;
					end
				end
				rtpsrt_pkg::S_SEARCH: begin
					if (!srch_busy) begin
						if (srch_hit) begin
							s_q <= srch_idx;
							state_q <= rtpsrt_pkg::S_LOAD;
						end else if (in_use_q >= limit_q || in_use_q >= 4'(N)) begin
							status_q <= rtpsrt_pkg::ST_FULL;
							state_q <= rtpsrt_pkg::S_DONE;
						end else begin
							s_q <= in_use_q[SB-1:0];
							in_use_q <= in_use_q + 1'b1;
							used_q[in_use_q[SB-1:0]] <= 1'b1;
							ssrc_mem[in_use_q[SB-1:0]] <= ssrc_q;
							high_q[in_use_q[SB-1:0]] <= seq_q;
							probe_q[in_use_q[SB-1:0]] <= seq_q;
							rel_q[in_use_q[SB-1:0]] <= seq_q - 16'd1;
							fill_q[in_use_q[SB-1:0]] <= 2'd0;
							state_q <= rtpsrt_pkg::S_LOAD;
						end
					end
				end
				rtpsrt_pkg::S_LOAD: begin
					hi_q <= high_q[s_q];
					pr_q <= probe_q[s_q];
					rl_q <= rel_q[s_q];
					fl_q <= fill_q[s_q];
					q0s_q <= qseq_q[s_q][0];
					q1s_q <= qseq_q[s_q][1];
					q0t_q <= qtag_q[s_q][0];
					q1t_q <= qtag_q[s_q][1];
					slot_q <= 3'(s_q);
					state_q <= rtpsrt_pkg::S_VALID;
				end
				rtpsrt_pkg::S_VALID: begin
					if (bad) begin
						if (seq_q == pr_q + 16'd1) begin
							probe_q[s_q] <= seq_q;
							high_q[s_q] <= seq_q;
							resync_q <= 1'b1;
							fcnt_q <= fl_q;
							if (fl_q >= 2'd1) ff_q <= 8'(q0t_q);
							if (fl_q >= 2'd2) fs_q <= 8'(q1t_q);
							fl_q <= 2'd0;
							fill_q[s_q] <= 2'd0;
							state_q <= rtpsrt_pkg::S_INSERT;
						end else begin
							probe_q[s_q] <= seq_q;
							high_q[s_q] <= hi_eff;
							status_q <= rtpsrt_pkg::ST_OUT_SEQ;
							state_q <= rtpsrt_pkg::S_DONE;
						end
					end else begin
						high_q[s_q] <= fwd ? seq_q : hi_eff;
						state_q <= rtpsrt_pkg::S_INSERT;
					end
				end
				rtpsrt_pkg::S_INSERT: begin
					state_q <= rtpsrt_pkg::S_DONE;
					if ((fl_q >= 2'd1 && !d0[15] && d0 == 16'd0)
						|| (fl_q >= 2'd2 && !d0[15] && !d1[15] && d1 == 16'd0)) begin
						status_q <= rtpsrt_pkg::ST_DUP;
					end else if (fl_q == 2'd2) begin
						// Three entries: the smallest leaves, the other two stay sorted.
						rv_q <= 1'b1;
						if (d0[15]) begin
							rt_q <= 8'(tag_q);
							rs_q <= seq_q;
							rg_q <= seq_q != rl_q + 16'd1;
							rel_q[s_q] <= seq_q;
						end else begin
							rt_q <= 8'(q0t_q);
							rs_q <= q0s_q;
							rg_q <= q0s_q != rl_q + 16'd1;
							rel_q[s_q] <= q0s_q;
							if (d1[15]) begin
								qseq_q[s_q][0] <= seq_q;
								qtag_q[s_q][0] <= tag_q;
							end else begin
								qseq_q[s_q][0] <= q1s_q;
								qtag_q[s_q][0] <= q1t_q;
								qseq_q[s_q][1] <= seq_q;
								qtag_q[s_q][1] <= tag_q;
							end
						end
					end else if (fl_q == 2'd1) begin
						fill_q[s_q] <= 2'd2;
						if (d0[15]) begin
							qseq_q[s_q][0] <= seq_q;
							qtag_q[s_q][0] <= tag_q;
							qseq_q[s_q][1] <= q0s_q;
							qtag_q[s_q][1] <= q0t_q;
						end else begin
							qseq_q[s_q][1] <= seq_q;
							qtag_q[s_q][1] <= tag_q;
						end
					end else begin
						fill_q[s_q] <= 2'd1;
						qseq_q[s_q][0] <= seq_q;
						qtag_q[s_q][0] <= tag_q;
					end
				end
				rtpsrt_pkg::S_DONE: begin
					status <= status_q;
					resynced <= resync_q;
					slot <= slot_q;
					flushed_count <= fcnt_q;
					flushed_first <= ff_q;
					flushed_second <= fs_q;
					release_valid <= rv_q;
					release_tag <= rt_q;
					release_sequence <= rs_q;
					release_gap <= rg_q;
					out_valid <= 1'b1;
					state_q <= rtpsrt_pkg::S_IDLE;
				end
				default: state_q <= rtpsrt_pkg::S_IDLE;
			endcase
		end
	end

	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[s_q] != 2'd3) else $error("queue overfilled");
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result while busy");
	a_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		in_use_q <= 4'(N)) else $error("slot count overflow");
	a_release_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && release_valid) |-> (status == rtpsrt_pkg::ST_OK))
		else $error("release with bad status");

endmodule
